// ===== src/bwr_pkg.sv =====
// shared types and address map constants for the banked work ram decoder
package bwr_pkg;

    // fixed address map
    localparam logic [15:0] WORK_BASE   = 16'hC000;
    localparam logic [15:0] SWITCH_BASE = 16'hD000;
    localparam logic [15:0] ECHO_BASE   = 16'hE000;
    localparam logic [15:0] ECHO_END    = 16'hFE00;
    localparam logic [15:0] HIGH_BASE   = 16'hFF80;
    localparam logic [15:0] ECHO_SHIFT  = 16'h2000;

    // bank geometry: 4 KiB per bank
    localparam int unsigned BANK_OFF_W = 12;
    localparam int unsigned BANK_SEL_W = 3;
    localparam logic [BANK_SEL_W-1:0] BANK_SEL_MASK = 3'h7;
    localparam logic [BANK_SEL_W-1:0] BANK_RESET    = 3'd1;

    // high ram
    localparam int unsigned HIGH_DEPTH = 128;
    localparam int unsigned HIGH_AW    = 7;

    // access kind codes
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // decoded target of one access
    typedef enum logic [2:0] {
        RGN_NONE,
        RGN_WORK,
        RGN_HIGH,
        RGN_BANKSEL,
        RGN_IRQ
    } t_region;

    // access held between the memory read and the output register
    typedef struct packed {
        logic    valid;
        logic    wr;
        t_region rgn;
        logic [7:0] reg_data;
    } t_s1;

endpackage

// ===== src/bwr_ram.sv =====
// generic single port ram with registered read
module bwr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write or read one entry; read data holds when idle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/bwr_decode.sv =====
// address decoder: echo folding, region select and memory indexes
module bwr_decode
    import bwr_pkg::*;
#(
    parameter int unsigned BANK_COUNT    = 8,
    parameter int unsigned BANK_SEL_ADDR = 65392,
    parameter int unsigned IRQ_FLAG_ADDR = 65295,
    localparam int unsigned BANK_W  = $clog2(BANK_COUNT),
    localparam int unsigned WORK_AW = BANK_W + BANK_OFF_W
) (
    input  logic [15:0]           i_addr,
    input  logic [BANK_SEL_W-1:0] i_bank,
    output t_region               o_rgn,
    output logic [WORK_AW-1:0]    o_work_idx,
    output logic [HIGH_AW-1:0]    o_high_idx
);

    localparam logic [15:0] BANKSEL_A = 16'(BANK_SEL_ADDR);
    localparam logic [15:0] IRQ_A     = 16'(IRQ_FLAG_ADDR);

    logic [15:0] eff_addr;
    logic [15:0] high_off;

    // fold the echo window down onto work ram
    always_comb begin
        if (i_addr >= ECHO_BASE && i_addr < ECHO_END) begin
            eff_addr = i_addr - ECHO_SHIFT;
        end else begin
            eff_addr = i_addr;
        end
    end

    // region select, bank select register wins over irq flags
    always_comb begin
        priority if (eff_addr >= WORK_BASE && eff_addr < ECHO_BASE) begin
            o_rgn = RGN_WORK;
        end else if (eff_addr >= HIGH_BASE) begin
            o_rgn = RGN_HIGH;
        end else if (eff_addr == BANKSEL_A) begin
            o_rgn = RGN_BANKSEL;
        end else if (eff_addr == IRQ_A) begin
            o_rgn = RGN_IRQ;
        end else begin
            o_rgn = RGN_NONE;
        end
    end

    // fixed bank 0 below the switch base, active bank above
    always_comb begin
        if (eff_addr < SWITCH_BASE) begin
            o_work_idx = {{BANK_W{1'b0}}, eff_addr[BANK_OFF_W-1:0]};
        end else begin
            o_work_idx = {i_bank[BANK_W-1:0], eff_addr[BANK_OFF_W-1:0]};
        end
    end

    assign high_off   = eff_addr - HIGH_BASE;
    assign o_high_idx = high_off[HIGH_AW-1:0];

endmodule

// ===== src/banked_work_ram_decoder_core.sv =====
// top level: banked work ram, high ram and the two byte registers
// path: an accepted access is held in stage 1, then in the output register
// throughput: one access per cycle while not clearing and the output is taken, set by the single port of each ram
// reset: synchronous; work ram and high ram are zeroed by a clearing pass
//   over every work ram entry, during which no access is taken
// reset: active bank 1, bank select byte 0, irq flags 0
module banked_work_ram_decoder_core
    import bwr_pkg::*;
#(
    parameter int unsigned BANK_COUNT    = 8,
    parameter int unsigned BANK_SEL_ADDR = 65392,
    parameter int unsigned IRQ_FLAG_ADDR = 65295
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_rdata,
    output logic        o_claimed
);

    localparam int unsigned BANK_W     = $clog2(BANK_COUNT);
    localparam int unsigned WORK_AW    = BANK_W + BANK_OFF_W;
    localparam int unsigned WORK_DEPTH = BANK_COUNT * (2 ** BANK_OFF_W);
    localparam logic [WORK_AW-1:0] CLR_LAST = WORK_AW'(WORK_DEPTH - 1);
    localparam logic [BANK_SEL_W:0] BANK_CNT_W = (BANK_SEL_W + 1)'(BANK_COUNT);

    // control and register state
    logic                  r_clr_busy, n_clr_busy;
    logic [WORK_AW-1:0]    r_clr_idx, n_clr_idx;
    logic [BANK_SEL_W-1:0] r_active_bank, n_active_bank;
    logic [7:0]            r_bank_sel_byte, n_bank_sel_byte;
    logic [7:0]            r_irq_flags, n_irq_flags;
    t_s1                   r_s1, n_s1;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_rdata, n_out_rdata;
    logic                  r_out_claimed, n_out_claimed;

    logic                  in_xfer;
    logic                  s1_go;
    t_region               dec_rgn;
    logic [WORK_AW-1:0]    dec_work_idx;
    logic [HIGH_AW-1:0]    dec_high_idx;
    logic                  work_en, work_we, high_en, high_we;
    logic [WORK_AW-1:0]    work_addr;
    logic [HIGH_AW-1:0]    high_addr;
    logic [7:0]            ram_wdata;
    logic [7:0]            work_rdata, high_rdata;
    logic [7:0]            s1_rdata;
    logic [BANK_SEL_W:0]   bank_calc;

    // handshake: stage 1 moves on when the output register is empty or being taken
    assign s1_go      = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_clr_busy && (!r_s1.valid || s1_go);
    assign in_xfer    = i_in_valid && o_in_ready;

    bwr_decode #(
        .BANK_COUNT    (BANK_COUNT),
        .BANK_SEL_ADDR (BANK_SEL_ADDR),
        .IRQ_FLAG_ADDR (IRQ_FLAG_ADDR)
    ) u_decode (
        .i_addr     (i_addr),
        .i_bank     (r_active_bank),
        .o_rgn      (dec_rgn),
        .o_work_idx (dec_work_idx),
        .o_high_idx (dec_high_idx)
    );

    // ram port muxing between the clearing pass and bus accesses
    always_comb begin
        if (r_clr_busy) begin
            work_en   = 1'b1;
            work_we   = 1'b1;
            work_addr = r_clr_idx;
            high_en   = 1'b1;
            high_we   = 1'b1;
            high_addr = r_clr_idx[HIGH_AW-1:0];
            ram_wdata = 8'h00;
        end else begin
            work_en   = in_xfer && (dec_rgn == RGN_WORK);
            work_we   = (i_func == FUNC_WRITE);
            work_addr = dec_work_idx;
            high_en   = in_xfer && (dec_rgn == RGN_HIGH);
            high_we   = (i_func == FUNC_WRITE);
            high_addr = dec_high_idx;
            ram_wdata = i_wdata;
        end
    end

    bwr_ram #(
        .WIDTH (8),
        .DEPTH (WORK_DEPTH)
    ) u_work_ram (
        .i_clk   (i_clk),
        .i_en    (work_en),
        .i_we    (work_we),
        .i_addr  (work_addr),
        .i_wdata (ram_wdata),
        .o_rdata (work_rdata)
    );

    bwr_ram #(
        .WIDTH (8),
        .DEPTH (HIGH_DEPTH)
    ) u_high_ram (
        .i_clk   (i_clk),
        .i_en    (high_en),
        .i_we    (high_we),
        .i_addr  (high_addr),
        .i_wdata (ram_wdata),
        .o_rdata (high_rdata)
    );

    // bank number from a written select byte: zero maps to one, wrap by count
    always_comb begin
        bank_calc = {1'b0, i_wdata[BANK_SEL_W-1:0] & BANK_SEL_MASK};
        if (bank_calc == '0) begin
            bank_calc = (BANK_SEL_W + 1)'(BANK_RESET);
        end
        for (int k = 0; k < 3; k++) begin
            if (bank_calc >= BANK_CNT_W) begin
                bank_calc = bank_calc - BANK_CNT_W;
            end
        end
        if (bank_calc == '0) begin
            bank_calc = (BANK_SEL_W + 1)'(BANK_RESET);
        end
    end

    // read data of the access in stage 1
    always_comb begin
        if (r_s1.wr) begin
            s1_rdata = 8'h00;
        end else begin
            unique case (r_s1.rgn)
                RGN_WORK:    s1_rdata = work_rdata;
                RGN_HIGH:    s1_rdata = high_rdata;
                RGN_BANKSEL: s1_rdata = r_s1.reg_data;
                RGN_IRQ:     s1_rdata = r_s1.reg_data;
                default:     s1_rdata = 8'h00;
            endcase
        end
    end

    // next state
    always_comb begin
        n_clr_busy      = r_clr_busy;
        n_clr_idx       = r_clr_idx;
        n_active_bank   = r_active_bank;
        n_bank_sel_byte = r_bank_sel_byte;
        n_irq_flags     = r_irq_flags;
        n_s1            = r_s1;
        n_out_valid     = r_out_valid;
        n_out_rdata     = r_out_rdata;
        n_out_claimed   = r_out_claimed;

        // clearing pass sweep
        if (r_clr_busy) begin
            if (r_clr_idx == CLR_LAST) begin
                n_clr_busy = 1'b0;
            end else begin
                n_clr_idx = r_clr_idx + 1'b1;
            end
        end

        // output register
        if (o_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_s1.valid && s1_go) begin
            n_out_valid   = 1'b1;
            n_out_rdata   = s1_rdata;
            n_out_claimed = (r_s1.rgn != RGN_NONE);
            n_s1.valid    = 1'b0;
        end

        // input transfer: register updates and stage 1 capture
        if (in_xfer) begin
            n_s1.valid    = 1'b1;
            n_s1.wr       = (i_func == FUNC_WRITE);
            n_s1.rgn      = dec_rgn;
            n_s1.reg_data = (dec_rgn == RGN_BANKSEL) ? r_bank_sel_byte : r_irq_flags;
            if (i_func == FUNC_WRITE) begin
                if (dec_rgn == RGN_BANKSEL) begin
                    n_active_bank   = bank_calc[BANK_SEL_W-1:0];
                    n_bank_sel_byte = i_wdata;
                end else if (dec_rgn == RGN_IRQ) begin
                    n_irq_flags = i_wdata;
                end
            end
        end
    end

    // control registers, stage 1 and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy      <= 1'b1;
            r_clr_idx       <= '0;
            r_active_bank   <= BANK_RESET;
            r_bank_sel_byte <= 8'h00;
            r_irq_flags     <= 8'h00;
            r_s1.valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_clr_busy      <= n_clr_busy;
            r_clr_idx       <= n_clr_idx;
            r_active_bank   <= n_active_bank;
            r_bank_sel_byte <= n_bank_sel_byte;
            r_irq_flags     <= n_irq_flags;
            r_s1            <= n_s1;
            r_out_valid     <= n_out_valid;
        end
    end

    // output payload registers
    always_ff @(posedge i_clk) begin
        r_out_rdata   <= n_out_rdata;
        r_out_claimed <= n_out_claimed;
    end

    assign o_out_valid = r_out_valid;
    assign o_rdata     = r_out_rdata;
    assign o_claimed   = r_out_claimed;

    // active bank is never zero and stays below the bank count
    a_bank_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_active_bank != '0) && ({1'b0, r_active_bank} < BANK_CNT_W))
        else $error("active bank out of range");

    // a full pipe with a stalled output takes no new transfer
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1.valid && r_out_valid && !i_out_ready) |-> !in_xfer)
        else $error("transfer taken while pipe is blocked");

    // every input transfer lands in stage 1
    a_s1_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_s1.valid)
        else $error("accepted access lost before stage 1");

    // clearing pass ends only after the last work ram entry
    a_clr_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> ($past(r_clr_idx) == CLR_LAST))
        else $error("clearing pass ended early");

endmodule
